// File: rtl/ccpc_pkg.sv
// shared types and constants for the character class pattern counter
// no dependencies; imported by every module of the block except ccpc_ram
package ccpc_pkg;

   localparam int TABLE_ENTRIES = 1024;
   localparam int MAX_WORD_LEN  = 10;

   localparam int IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W     = $clog2(TABLE_ENTRIES + 1);
   localparam int POS_W     = $clog2(MAX_WORD_LEN + 1);
   localparam int MASK_W    = 20;
   localparam int OCC_W     = 32;
   localparam int ENTRY_W   = MASK_W + OCC_W;
   localparam int OUT_IDX_W = 10;
   localparam int USED_W    = 11;
   localparam int WLEN_W    = 4;
   localparam int CHAR_W    = 8;

   localparam logic [WLEN_W-1:0] WORD_LENGTH_RESET = 4'd8;

   typedef enum logic [2:0] {
      ST_COUNTED  = 3'd0,
      ST_ADDED    = 3'd1,
      ST_SHORT    = 3'd2,
      ST_LONG     = 3'd3,
      ST_BAD      = 3'd4,
      ST_FULL     = 3'd5,
      ST_READ_OK  = 3'd6,
      ST_READ_BAD = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      V_OK    = 2'd0,
      V_SHORT = 2'd1,
      V_LONG  = 2'd2,
      V_BAD   = 2'd3
   } verdict_type;

   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_SCAN  = 2'd1,
      S_RDATA = 2'd2,
      S_DONE  = 2'd3
   } fsm_type;

   typedef struct packed {
      logic              done;
      verdict_type       verdict;
      logic [MASK_W-1:0] mask;
   } word_end_type;

   typedef struct packed {
      logic                 valid;
      status_type           status;
      logic [MASK_W-1:0]    mask;
      logic [OUT_IDX_W-1:0] index;
      logic [OCC_W-1:0]     occ;
   } result_type;

endpackage

// File: rtl/ccpc_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module ccpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ccpc_word.sv
// word assembler: classes each byte and builds the 2-bit-per-position mask
// depends on ccpc_pkg
module ccpc_word import ccpc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_valid,
   input  logic [CHAR_W-1:0] char_byte,
   input  logic [WLEN_W-1:0] word_length,
   output word_end_type      word_end
);

   typedef enum logic [1:0] {
      RJ_NONE = 2'd0,
      RJ_LONG = 2'd1,
      RJ_BAD  = 2'd2
   } reject_type;

   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
   localparam logic [2:0]        CLASS_BAD    = 3'd4;

   function automatic logic [2:0] char_class(input logic [CHAR_W-1:0] c);
      logic [2:0] cl;
      cl = CLASS_BAD;
      if (c >= "0" && c <= "9") cl = 3'd0;
      else if (c >= "a" && c <= "z") cl = 3'd1;
      else if (c >= "A" && c <= "Z") cl = 3'd2;
      else if ((c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126))
         cl = 3'd3;
      return cl;
   endfunction

   logic [MASK_W-1:0] word_mask_ff, word_mask_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   reject_type        reject_ff, reject_in;
   logic [POS_W-1:0]  active_len;
   logic [2:0]        cl;
   logic              is_end;

   // register value 0 acts as 1, values above the maximum clamp
   always_comb begin
      if (word_length == '0) begin
         active_len = POS_W'(1);
      end else if (32'(word_length) > MAX_WORD_LEN) begin
         active_len = POS_W'(MAX_WORD_LEN);
      end else begin
         active_len = POS_W'(word_length);
      end
   end

   assign cl     = char_class(char_byte);
   assign is_end = (char_byte == CHAR_NEWLINE) || (char_byte == CHAR_NUL);

   always_comb begin
      word_mask_in = word_mask_ff;
      pos_in       = pos_ff;
      reject_in    = reject_ff;
      if (byte_valid) begin
         if (is_end) begin
            word_mask_in = '0;
            pos_in       = '0;
            reject_in    = RJ_NONE;
         end else if (reject_ff == RJ_NONE) begin
            if (pos_ff >= active_len) begin
               reject_in = RJ_LONG;
            end else if (cl == CLASS_BAD) begin
               reject_in = RJ_BAD;
            end else begin
               for (int p = 0; p < MAX_WORD_LEN; p++) begin
                  if (pos_ff == POS_W'(p)) begin
                     word_mask_in[2*p +: 2] = word_mask_ff[2*p +: 2] | cl[1:0];
                  end
               end
               pos_in = pos_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_mask_ff <= '0;
         pos_ff       <= '0;
         reject_ff    <= RJ_NONE;
      end else begin
         word_mask_ff <= word_mask_in;
         pos_ff       <= pos_in;
         reject_ff    <= reject_in;
      end
   end

   always_comb begin
      word_end.done = byte_valid && is_end;
      word_end.mask = word_mask_ff;
      if (reject_ff == RJ_LONG) begin
         word_end.verdict = V_LONG;
      end else if (reject_ff == RJ_BAD) begin
         word_end.verdict = V_BAD;
      end else if (pos_ff < active_len) begin
         word_end.verdict = V_SHORT;
      end else begin
         word_end.verdict = V_OK;
      end
   end

endmodule

// File: rtl/ccpc_seq.sv
// table sequencer: linear search with one shared compare, append, count update
// depends on ccpc_pkg; drives the table ram ports
module ccpc_seq import ccpc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_accept,
   input  logic                 req_func,
   input  logic [OUT_IDX_W-1:0] req_read_index,
   input  word_end_type         word_end,
   input  logic                 res_taken,
   output logic                 busy,
   output result_type           result,
   output logic [CNT_W-1:0]     entry_count,
   output logic                 ram_wr_en,
   output logic [IDX_W-1:0]     ram_wr_addr,
   output logic [ENTRY_W-1:0]   ram_wr_data,
   output logic [IDX_W-1:0]     ram_rd_addr,
   input  logic [ENTRY_W-1:0]   ram_rd_data
);

   fsm_type              state_ff, state_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic                 cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic [CNT_W-1:0]     entry_count_ff, entry_count_in;
   status_type           res_status_ff, res_status_in;
   logic [MASK_W-1:0]    res_mask_ff, res_mask_in;
   logic [OUT_IDX_W-1:0] res_index_ff, res_index_in;
   logic [OCC_W-1:0]     res_occ_ff, res_occ_in;

   logic [MASK_W-1:0] rd_mask;
   logic [OCC_W-1:0]  rd_count, sat_inc;
   logic              issuing, hit, read_ok, has_room;

   assign rd_mask  = ram_rd_data[MASK_W-1:0];
   assign rd_count = ram_rd_data[ENTRY_W-1:MASK_W];
   assign sat_inc  = (&rd_count) ? rd_count : rd_count + 32'd1;
   assign issuing  = (state_ff == S_SCAN) && (idx_ff < entry_count_ff);
   assign hit      = (state_ff == S_SCAN) && cmp_valid_ff && (rd_mask == res_mask_ff);
   assign read_ok  = 32'(req_read_index) < 32'(entry_count_ff);
   assign has_room = 32'(entry_count_ff) < TABLE_ENTRIES;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_func) begin
                  state_in = read_ok ? S_RDATA : S_DONE;
               end else if (word_end.done) begin
                  state_in = (word_end.verdict == V_OK) ? S_SCAN : S_DONE;
               end
            end
         end
         S_SCAN: begin
            if (hit || !issuing) state_in = S_DONE;
         end
         S_RDATA: state_in = S_DONE;
         S_DONE: begin
            if (res_taken) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and ram control
   always_comb begin
      idx_in         = idx_ff;
      cmp_valid_in   = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      entry_count_in = entry_count_ff;
      res_status_in  = res_status_ff;
      res_mask_in    = res_mask_ff;
      res_index_in   = res_index_ff;
      res_occ_in     = res_occ_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = cmp_idx_ff;
      ram_wr_data    = {sat_inc, res_mask_ff};
      ram_rd_addr    = (state_ff == S_IDLE) ? IDX_W'(req_read_index) : idx_ff[IDX_W-1:0];
      case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (req_accept) begin
               if (req_func) begin
                  res_index_in  = req_read_index;
                  res_status_in = ST_READ_BAD;
                  res_mask_in   = '0;
                  res_occ_in    = '0;
               end else if (word_end.done) begin
                  res_mask_in  = '0;
                  res_index_in = '0;
                  res_occ_in   = '0;
                  case (word_end.verdict)
                     V_OK:    res_mask_in   = word_end.mask;
                     V_SHORT: res_status_in = ST_SHORT;
                     V_LONG:  res_status_in = ST_LONG;
                     V_BAD:   res_status_in = ST_BAD;
                     default: res_status_in = ST_BAD;
                  endcase
               end
            end
         end
         S_SCAN: begin
            // reads run one entry ahead of the compare
            cmp_valid_in = issuing;
            cmp_idx_in   = idx_ff[IDX_W-1:0];
            if (issuing) idx_in = idx_ff + 1'b1;
            if (hit) begin
               ram_wr_en     = 1'b1;
               res_status_in = ST_COUNTED;
               res_index_in  = OUT_IDX_W'(cmp_idx_ff);
               res_occ_in    = sat_inc;
            end else if (!issuing) begin
               if (has_room) begin
                  ram_wr_en      = 1'b1;
                  ram_wr_addr    = entry_count_ff[IDX_W-1:0];
                  ram_wr_data    = {32'd1, res_mask_ff};
                  entry_count_in = entry_count_ff + 1'b1;
                  res_status_in  = ST_ADDED;
                  res_index_in   = OUT_IDX_W'(entry_count_ff);
                  res_occ_in     = 32'd1;
               end else begin
                  res_status_in = ST_FULL;
                  res_index_in  = '0;
                  res_occ_in    = '0;
               end
            end
         end
         S_RDATA: begin
            res_status_in = ST_READ_OK;
            res_mask_in   = rd_mask;
            res_occ_in    = rd_count;
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         cmp_valid_ff   <= 1'b0;
         entry_count_ff <= '0;
      end else begin
         state_ff       <= state_in;
         cmp_valid_ff   <= cmp_valid_in;
         entry_count_ff <= entry_count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      res_status_ff <= res_status_in;
      res_mask_ff   <= res_mask_in;
      res_index_ff  <= res_index_in;
      res_occ_ff    <= res_occ_in;
   end

   // outputs
   always_comb begin
      busy          = (state_ff != S_IDLE);
      result.valid  = (state_ff == S_DONE);
      result.status = res_status_ff;
      result.mask   = res_mask_ff;
      result.index  = res_index_ff;
      result.occ    = res_occ_ff;
      entry_count   = entry_count_ff;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(entry_count_ff) <= TABLE_ENTRIES)
      else $error("entry count above table size");

   a_cmp_in_range: assert property (@(posedge clock) disable iff (reset)
      cmp_valid_ff |-> (CNT_W'(cmp_idx_ff) < entry_count_ff))
      else $error("compare on an entry that was never written");

   a_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == S_SCAN))
      else $error("table write outside the search");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (entry_count_ff != $past(entry_count_ff))) |->
      (entry_count_ff == CNT_W'($past(entry_count_ff) + 1'b1)))
      else $error("entry count moved by more than one");
`endif

endmodule

// File: rtl/char_class_pattern_counter.sv
// a byte that does not end a word is taken with no result; a word end or a read gives one;
// the search compares one table entry per cycle through the single table read port
// one item at a time: req_stall is high from acceptance of a word end or read until
// the result is registered
// reset is synchronous: clears the word, entry count and word_length (to 8);
// table contents are not cleared, entries at or above the count are never read
module char_class_pattern_counter import ccpc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_func,
   input  logic [CHAR_W-1:0]    req_char_byte,
   input  logic [OUT_IDX_W-1:0] req_read_index,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_status,
   output logic [MASK_W-1:0]    rsp_mask,
   output logic [OUT_IDX_W-1:0] rsp_entry_index,
   output logic [OCC_W-1:0]     rsp_occurrences,
   output logic [USED_W-1:0]    rsp_entries_used,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [WLEN_W-1:0]    csr_word_length
);

   logic [WLEN_W-1:0]    word_length_ff, word_length_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_status_ff;
   logic [MASK_W-1:0]    rsp_mask_ff;
   logic [OUT_IDX_W-1:0] rsp_index_ff;
   logic [OCC_W-1:0]     rsp_occ_ff;
   logic [USED_W-1:0]    rsp_used_ff;

   logic                 req_accept, busy, res_taken;
   word_end_type         word_end;
   result_type           result;
   logic [CNT_W-1:0]     entry_count;
   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr, ram_rd_addr;
   logic [ENTRY_W-1:0]   ram_wr_data, ram_rd_data;

   assign req_stall  = busy;
   assign req_accept = req_valid && !busy;
   assign csr_ready  = 1'b1;

   assign word_length_in = (csr_valid && csr_ready) ? csr_word_length : word_length_ff;

   ccpc_word u_word (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (req_accept && !req_func),
      .char_byte   (req_char_byte),
      .word_length (word_length_ff),
      .word_end    (word_end)
   );

   ccpc_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_accept     (req_accept),
      .req_func       (req_func),
      .req_read_index (req_read_index),
      .word_end       (word_end),
      .res_taken      (res_taken),
      .busy           (busy),
      .result         (result),
      .entry_count    (entry_count),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data)
   );

   // count in the upper bits, mask in the lower bits
   ccpc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // output register: loads when empty or when the waiting transaction leaves
   assign res_taken    = result.valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = res_taken || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         word_length_ff <= WORD_LENGTH_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         word_length_ff <= word_length_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_taken) begin
         rsp_status_ff <= result.status;
         rsp_mask_ff   <= result.mask;
         rsp_index_ff  <= result.index;
         rsp_occ_ff    <= result.occ;
         rsp_used_ff   <= USED_W'(entry_count);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_mask         = rsp_mask_ff;
   assign rsp_entry_index  = rsp_index_ff;
   assign rsp_occurrences  = rsp_occ_ff;
   assign rsp_entries_used = rsp_used_ff;

endmodule
